>>> src/tiny_mcu_instruction_executor_defines.svh
// Assertion helpers used by the checker file.
`ifndef TINY_MCU_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define TINY_MCU_INSTRUCTION_EXECUTOR_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define TME_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define TME_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

>>> src/tme_pkg.sv
package tme_pkg;

  localparam int unsigned RegCount = 4;
  localparam int unsigned RamDepth = 16;
  localparam int unsigned PinCount = 6;

  localparam int unsigned DataW    = 8;
  localparam int unsigned PinPortW = 6;
  localparam int unsigned PinW     = (PinCount > PinPortW) ? PinCount : PinPortW;
  localparam int unsigned MemDepth = RegCount + RamDepth;
  localparam int unsigned MemAw    = $clog2(MemDepth);
  localparam int unsigned DivCntW  = $clog2(DataW);

  typedef enum logic [4:0] {
    OP_MOV = 5'd0,
    OP_ADD = 5'd1,
    OP_SUB = 5'd2,
    OP_MUL = 5'd3,
    OP_DIV = 5'd4,
    OP_MOD = 5'd5,
    OP_AND = 5'd6,
    OP_OR  = 5'd7,
    OP_XOR = 5'd8,
    OP_SHL = 5'd9,
    OP_SHR = 5'd10,
    OP_CMP = 5'd11,
    OP_JG  = 5'd12,
    OP_JGE = 5'd13,
    OP_JL  = 5'd14,
    OP_JLE = 5'd15,
    OP_JMP = 5'd16,
    OP_GET = 5'd17,
    OP_SET = 5'd18
  } op_e;

  // Two's complement codes of the three-way compare flag.
  typedef enum logic [1:0] {
    CMP_EQ = 2'b00,
    CMP_GT = 2'b01,
    CMP_LT = 2'b11
  } cmp_e;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
    logic [DataW-1:0] remainder;
  } div_rsp_t;

  // Fold a 4-bit operand index into 0..n-1 by repeated subtraction.
  function automatic logic [3:0] wrap_idx(input logic [3:0] idx, input int unsigned n);
    logic [4:0] r;
    r = {1'b0, idx};
    for (int k = 0; k < 8; k++) begin
      if (int'(r) >= n) begin
        r = r - 5'(n);
      end
    end
    return r[3:0];
  endfunction

  // Registers sit at the bottom of the shared memory, RAM bytes above them.
  function automatic logic [MemAw-1:0] mem_addr(input logic is_ram, input logic [3:0] idx);
    if (is_ram) begin
      return MemAw'(RegCount) + MemAw'(wrap_idx(idx, RamDepth));
    end
    return MemAw'(wrap_idx(idx, RegCount));
  endfunction

endpackage

>>> src/tme_in_if.sv
interface tme_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] operation;
  logic       dst_is_ram;
  logic [3:0] dst_index;
  logic       src_is_ram;
  logic [3:0] src_index;
  logic [5:0] ext_pin_levels;

  modport source (
    output valid, operation, dst_is_ram, dst_index, src_is_ram, src_index, ext_pin_levels,
    input  ready
  );
  modport sink (
    input  valid, operation, dst_is_ram, dst_index, src_is_ram, src_index, ext_pin_levels,
    output ready
  );
endinterface

>>> src/tme_out_if.sv
interface tme_out_if;
  logic              valid;
  logic              ready;
  logic        [7:0] next_pc;
  logic        [5:0] pin_levels;
  logic signed [1:0] compare_state;
  logic              divide_by_zero;
  logic        [7:0] written_value;

  modport source (
    output valid, next_pc, pin_levels, compare_state, divide_by_zero, written_value,
    input  ready
  );
  modport sink (
    input  valid, next_pc, pin_levels, compare_state, divide_by_zero, written_value,
    output ready
  );
endinterface

>>> src/tiny_mcu_instruction_executor.sv
// Sequence: the operands are read from memory on the input transfer, executed in the read
//   state, then written back and handed off; div or mod with a nonzero divisor first waits for
//   the eight steps of the radix-2 divider. A new instruction is taken only once the last one
//   has been handed off, and hand-off waits while the output slot is full.
// Reset: registers, RAM, compare flag, program counter, pin latches and input mask read as
//   zero right after reset; per-entry valid bits cover the memory, so no clearing pass.
module tiny_mcu_instruction_executor (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  tme_in_if.sink    in_i,
  tme_out_if.source out_o
);
  import tme_pkg::*;

  // One-hot sequencer: idle, operand read, divider wait, write back and hand off.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e st_q, st_d;

  // Instruction held for the duration of its execution.
  op_e              op_q;
  logic [MemAw-1:0] dst_addr_q;
  logic [3:0]       sidx_q;
  logic [5:0]       ext_q;

  // Architectural state kept outside the memory.
  cmp_e                cmp_q, cmp_d;
  logic [7:0]          pc_q;
  logic [PinCount-1:0] pin_q, pin_d, mask_q;

  // Execution results waiting for write back.
  logic [7:0] res_q;
  logic       wrote_q, dz_q;

  // Output slot, decoupled from the sequencer.
  logic              ov_q;
  logic        [7:0] o_pc_q, o_wv_q;
  logic        [5:0] o_pin_q;
  logic signed [1:0] o_cmp_q;
  logic              o_dz_q;

  logic             in_acc, slot_free, commit, mem_we;
  logic [MemAw-1:0] rd_addr_a, rd_addr_b;
  logic [7:0]       a, b;
  logic [7:0]       alu_res;
  logic             alu_wr, alu_dz, div_go, jump, lvl;
  logic [PinW-1:0]  ext_w, pin_w, cfg_w;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign in_i.ready = (st_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign slot_free  = !ov_q || out_o.ready;
  assign commit     = (st_q == ST_DONE) && slot_free;
  assign mem_we     = commit && wrote_q;

  // Only mov may target a RAM byte; every other operation's destination is a register.
  assign rd_addr_a = mem_addr((op_e'(in_i.operation) == OP_MOV) && in_i.dst_is_ram,
                              in_i.dst_index);
  assign rd_addr_b = mem_addr(in_i.src_is_ram, in_i.src_index);

  // Registers and RAM share one memory: port A fetches the destination, port B the source.
  tme_ram #(
    .Depth (MemDepth),
    .Width (DataW)
  ) u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (mem_we),
    .waddr_i   (dst_addr_q),
    .wdata_i   (res_q),
    .re_i      (in_acc),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (a),
    .rdata_b_o (b)
  );

  assign div_req.start    = div_go;
  assign div_req.dividend = a;
  assign div_req.divisor  = b;

  tme_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign ext_w = PinW'(ext_q);
  assign pin_w = PinW'(pin_q);
  assign cfg_w = PinW'(cfg_wdata_i);

  // Execute: operands arrive from memory in the read state.
  always_comb begin
    alu_res = '0;
    alu_wr  = 1'b0;
    alu_dz  = 1'b0;
    div_go  = 1'b0;
    jump    = 1'b0;
    lvl     = 1'b0;
    cmp_d   = cmp_q;
    pin_d   = pin_q;
    // Pin read: input pins follow the external level, the rest echo the latch.
    for (int i = 0; i < PinCount; i++) begin
      if (int'(sidx_q) == i) begin
        lvl = mask_q[i] ? ext_w[i] : pin_q[i];
      end
    end
    case (op_q)
      OP_MOV: begin
        alu_res = b;
        alu_wr  = 1'b1;
      end
      OP_ADD: begin
        alu_res = a + b;
        alu_wr  = 1'b1;
      end
      OP_SUB: begin
        alu_res = a - b;
        alu_wr  = 1'b1;
      end
      OP_MUL: begin
        alu_res = 8'(a * b);
        alu_wr  = 1'b1;
      end
      OP_DIV, OP_MOD: begin
        // Zero divisor: keep the destination, raise the flag.
        if (b == '0) begin
          alu_dz = 1'b1;
        end else begin
          div_go = (st_q == ST_READ);
        end
      end
      OP_AND: begin
        alu_res = a & b;
        alu_wr  = 1'b1;
      end
      OP_OR: begin
        alu_res = a | b;
        alu_wr  = 1'b1;
      end
      OP_XOR: begin
        alu_res = a ^ b;
        alu_wr  = 1'b1;
      end
      OP_SHL: begin
        alu_res = (b[7:3] != '0) ? '0 : (a << b[2:0]);
        alu_wr  = 1'b1;
      end
      OP_SHR: begin
        alu_res = (b[7:3] != '0) ? '0 : (a >> b[2:0]);
        alu_wr  = 1'b1;
      end
      OP_CMP: begin
        if (a == b) begin
          cmp_d = CMP_EQ;
        end else if (a > b) begin
          cmp_d = CMP_GT;
        end else begin
          cmp_d = CMP_LT;
        end
      end
      OP_JG:  jump = (cmp_q == CMP_GT);
      OP_JGE: jump = (cmp_q != CMP_LT);
      OP_JL:  jump = (cmp_q == CMP_LT);
      OP_JLE: jump = (cmp_q != CMP_GT);
      OP_JMP: jump = 1'b1;
      OP_GET: begin
        alu_res = {a[7:1], lvl};
        alu_wr  = 1'b1;
      end
      OP_SET: begin
        // Pin numbers past the last pin leave the latches alone.
        for (int i = 0; i < PinCount; i++) begin
          if (int'(sidx_q) == i) begin
            pin_d[i] = a[0];
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_acc)           st_d = ST_READ;
      ST_READ: st_d = div_go ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_rsp.done)     st_d = ST_DONE;
      ST_DONE: if (slot_free)        st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      cmp_q   <= CMP_EQ;
      pc_q    <= '0;
      pin_q   <= '0;
      mask_q  <= '0;
      wrote_q <= 1'b0;
      dz_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        mask_q <= cfg_w[PinCount-1:0];
      end
      // Update flag, latches and counter in the execute cycle; the counter
      // always advances, after a taken jump too.
      if (st_q == ST_READ) begin
        cmp_q   <= cmp_d;
        pin_q   <= pin_d;
        pc_q    <= (jump ? b : pc_q) + 8'd1;
        wrote_q <= alu_wr;
        dz_q    <= alu_dz;
      end else if ((st_q == ST_DIV) && div_rsp.done) begin
        wrote_q <= 1'b1;
      end
      // Hold the result while the sink stalls; drop it once transferred.
      if (commit) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q       <= op_e'(in_i.operation);
      dst_addr_q <= rd_addr_a;
      sidx_q     <= in_i.src_index;
      ext_q      <= in_i.ext_pin_levels;
    end
    if (st_q == ST_READ) begin
      res_q <= alu_res;
    end else if ((st_q == ST_DIV) && div_rsp.done) begin
      res_q <= (op_q == OP_DIV) ? div_rsp.quotient : div_rsp.remainder;
    end
    if (commit) begin
      o_pc_q  <= pc_q;
      o_pin_q <= pin_w[PinPortW-1:0];
      o_cmp_q <= $signed(cmp_q);
      o_dz_q  <= dz_q;
      o_wv_q  <= wrote_q ? res_q : '0;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.next_pc        = o_pc_q;
  assign out_o.pin_levels     = o_pin_q;
  assign out_o.compare_state  = o_cmp_q;
  assign out_o.divide_by_zero = o_dz_q;
  assign out_o.written_value  = o_wv_q;

endmodule

>>> src/tme_ram.sv
module tme_ram #(
  parameter int unsigned Depth = 20,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [Width-1:0] rdata_a_q, rdata_b_q;

  // Entries never written read as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= vld_q[raddr_a_i] ? mem[raddr_a_i] : '0;
      rdata_b_q <= vld_q[raddr_b_i] ? mem[raddr_b_i] : '0;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> src/tme_div.sv
module tme_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tme_pkg::div_req_t req_i,
  output tme_pkg::div_rsp_t rsp_o
);
  import tme_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DataW-1:0]   quo_q, rem_q, dsr_q;
  logic [DataW:0]     shifted;
  logic               fits;

  // Restoring radix-2 step: shift in the next dividend bit, subtract if it fits.
  assign shifted = {rem_q, quo_q[DataW-1]};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DataW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? DataW'(shifted - {1'b0, dsr_q}) : shifted[DataW-1:0];
      quo_q <= {quo_q[DataW-2:0], fits};
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> src/tme_chk.sv
`include "tiny_mcu_instruction_executor_defines.svh"

module tme_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic        [7:0] next_pc,
  input logic signed [1:0] compare_state,
  input logic              divide_by_zero,
  input logic        [7:0] written_value
);

  // A stalled result keeps its program counter, written value and compare state.
  `TME_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(next_pc) && $stable(written_value) && $stable(compare_state))

  // One instruction at a time: no new transfer right after one is taken.
  `TME_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // A zero divisor leaves the destination untouched.
  `TME_ASSERT_IMP(a_dz_no_write, out_valid && divide_by_zero, written_value == 8'd0)

  // A fresh result never shows up the cycle after an input transfer.
  `TME_ASSERT_IMP(a_no_early_result, $rose(out_valid), !$past(in_valid && in_ready))

endmodule

bind tiny_mcu_instruction_executor tme_chk u_tme_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .next_pc        (out_o.next_pc),
  .compare_state  (out_o.compare_state),
  .divide_by_zero (out_o.divide_by_zero),
  .written_value  (out_o.written_value)
);
